>>> hdl/ffpa_pkg.sv
// ----------------------------------------------------------------------------
// First-fit pool allocator package
// Shared constants, status codes, sequencer states and the per-cell control
// word of the block table.
// ----------------------------------------------------------------------------
package ffpa_pkg;

  localparam int unsigned FUNC_W = 1;
  localparam int unsigned SIZE_W = 10;
  localparam int unsigned OFFS_W = 10;
  localparam int unsigned STAT_W = 2;

  localparam int unsigned POOL_BYTES_DEF   = 1024;
  localparam int unsigned HEADER_BYTES_DEF = 32;
  localparam int unsigned MAX_BLOCKS_DEF   = 32;

  localparam logic [FUNC_W-1:0] FUNC_ALLOC = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_FREE  = 1'b1;

  localparam logic [STAT_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_ZERO     = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_NO_FIT   = 2'd2;
  localparam logic [STAT_W-1:0] STATUS_BAD_FREE = 2'd3;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_EVAL   = 7'b0000010,
    S_DECIDE = 7'b0000100,
    S_ACT    = 7'b0001000,
    S_MNEXT  = 7'b0010000,
    S_MPREV  = 7'b0100000,
    S_RESP   = 7'b1000000
  } state_t;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_EVAL,
    CMD_ALLOC,
    CMD_FREE,
    CMD_MERGE
  } cmd_op_t;

  typedef struct packed {
    logic eval;
    logic set_used;
    logic trim;
    logic split_in;
    logic take_left;
    logic set_free;
    logic absorb;
    logic take_right;
  } cell_ctl_t;

endpackage

>>> hdl/ffpa_if.sv
// ----------------------------------------------------------------------------
// First-fit pool allocator channels
// Valid/ready channels for allocate and free requests and for their results.
// ----------------------------------------------------------------------------
interface ffpa_req_if;
  logic                        valid;
  logic                        ready;
  logic [ffpa_pkg::FUNC_W-1:0] func;
  logic [ffpa_pkg::SIZE_W-1:0] req_size;
  logic [ffpa_pkg::OFFS_W-1:0] free_offset;

  modport source (output valid, func, req_size, free_offset, input ready);
  modport sink (input valid, func, req_size, free_offset, output ready);
endinterface

interface ffpa_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [ffpa_pkg::STAT_W-1:0] status;
  logic [ffpa_pkg::OFFS_W-1:0] payload_offset;

  modport source (output valid, status, payload_offset, input ready);
  modport sink (input valid, status, payload_offset, output ready);
endinterface

>>> hdl/ffpa_cell.sv
// ----------------------------------------------------------------------------
// First-fit pool allocator table cell
// Holds one block entry, evaluates it against the current request and takes
// an entry from its left or right neighbor when the table shifts.
// ----------------------------------------------------------------------------
module ffpa_cell #(
  parameter int unsigned POOL_BYTES   = ffpa_pkg::POOL_BYTES_DEF,
  parameter int unsigned HEADER_BYTES = ffpa_pkg::HEADER_BYTES_DEF,
  parameter bit          IS_HEAD      = 1'b0
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ffpa_pkg::cell_ctl_t           ctl,
  input  logic [ffpa_pkg::FUNC_W-1:0]   func,
  input  logic [ffpa_pkg::SIZE_W-1:0]   req_size,
  input  logic [ffpa_pkg::OFFS_W-1:0]   free_offset,
  input  logic                          left_valid,
  input  logic                          left_free,
  input  logic [$clog2(POOL_BYTES+1)-1:0] left_start,
  input  logic [$clog2(POOL_BYTES+1)-1:0] left_size,
  input  logic                          right_valid,
  input  logic                          right_free,
  input  logic [$clog2(POOL_BYTES+1)-1:0] right_start,
  input  logic [$clog2(POOL_BYTES+1)-1:0] right_size,
  output logic                          valid,
  output logic                          free,
  output logic [$clog2(POOL_BYTES+1)-1:0] start,
  output logic [$clog2(POOL_BYTES+1)-1:0] size,
  output logic                          match,
  output logic                          split
);

  localparam int unsigned ADDR_W = $clog2(POOL_BYTES + 1);
  localparam int unsigned SUM_W  = ((ADDR_W > 11) ? ADDR_W : 11) + 1;
  localparam logic [SUM_W-1:0]  HDR = SUM_W'(HEADER_BYTES);
  localparam logic [ADDR_W-1:0] INIT_SIZE =
    (POOL_BYTES > HEADER_BYTES) ? ADDR_W'(POOL_BYTES - HEADER_BYTES) : '0;

  logic              valid_r, valid_nxt;
  logic              free_r, free_nxt;
  logic [ADDR_W-1:0] start_r, start_nxt;
  logic [ADDR_W-1:0] size_r, size_nxt;
  logic              match_r, match_nxt;
  logic              split_r, split_nxt;
  logic [SUM_W-1:0]  req_w;
  logic [SUM_W-1:0]  start_w;
  logic [SUM_W-1:0]  size_w;

  assign req_w   = SUM_W'(req_size);
  assign start_w = SUM_W'(start_r);
  assign size_w  = SUM_W'(size_r);

  always_comb begin
    valid_nxt = valid_r;
    free_nxt  = free_r;
    start_nxt = start_r;
    size_nxt  = size_r;
    match_nxt = match_r;
    split_nxt = split_r;
    if (ctl.eval) begin
      if (func == ffpa_pkg::FUNC_FREE) begin
        match_nxt = valid_r && (start_w + HDR == SUM_W'(free_offset));
      end else begin
        match_nxt = valid_r && free_r && (size_w >= req_w);
      end
      split_nxt = size_w >= req_w + HDR + SUM_W'(1);
    end else if (ctl.set_used) begin
      free_nxt = 1'b0;
      if (ctl.trim) begin
        size_nxt = ADDR_W'(req_w);
      end
    end else if (ctl.split_in) begin
      valid_nxt = 1'b1;
      free_nxt  = 1'b1;
      start_nxt = ADDR_W'(SUM_W'(left_start) + HDR + req_w);
      size_nxt  = ADDR_W'(SUM_W'(left_size) - HDR - req_w);
    end else if (ctl.take_left) begin
      valid_nxt = left_valid;
      free_nxt  = left_free;
      start_nxt = left_start;
      size_nxt  = left_size;
    end else if (ctl.set_free) begin
      free_nxt = 1'b1;
    end else if (ctl.absorb) begin
      size_nxt = ADDR_W'(size_w + HDR + SUM_W'(right_size));
    end else if (ctl.take_right) begin
      valid_nxt = right_valid;
      free_nxt  = right_free;
      start_nxt = right_start;
      size_nxt  = right_size;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= IS_HEAD;
      free_r  <= IS_HEAD;
      start_r <= '0;
      size_r  <= IS_HEAD ? INIT_SIZE : '0;
      match_r <= 1'b0;
      split_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      free_r  <= free_nxt;
      start_r <= start_nxt;
      size_r  <= size_nxt;
      match_r <= match_nxt;
      split_r <= split_nxt;
    end
  end

  assign valid = valid_r;
  assign free  = free_r;
  assign start = start_r;
  assign size  = size_r;
  assign match = match_r;
  assign split = split_r;

endmodule

>>> hdl/first_fit_pool_allocator_unit.sv
// ----------------------------------------------------------------------------
// First-fit pool allocator with coalescing
// The block table is a row of cells in address order; allocate takes and may
// split the first fitting free block; free merges a block with free neighbors.
// ----------------------------------------------------------------------------
// One request is handled at a time. A zero-size allocate goes straight from
// acceptance to the result stage; any other request steps through the
// sequencer states below before its result is registered, after which the next
// request can be accepted; a finished result waits in the output register while
// the next request is taken. The sequencer steps the cell row: it evaluates all
// cells, picks the first match, and then applies the table updates (mark or
// split, and for a free, merge with the next block and merge with the previous
// block), each split or merge moving the entries above it by one cell.
module first_fit_pool_allocator_unit #(
  parameter int unsigned POOL_BYTES   = ffpa_pkg::POOL_BYTES_DEF,
  parameter int unsigned HEADER_BYTES = ffpa_pkg::HEADER_BYTES_DEF,
  parameter int unsigned MAX_BLOCKS   = ffpa_pkg::MAX_BLOCKS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  ffpa_req_if.sink   in_chan,
  ffpa_rsp_if.source out_chan
);

  localparam int unsigned ADDR_W = $clog2(POOL_BYTES + 1);
  localparam int unsigned IDX_W  = $clog2(MAX_BLOCKS);
  localparam int unsigned SUM_W  = ((ADDR_W > 11) ? ADDR_W : 11) + 1;

  ffpa_pkg::state_t              state_r, state_nxt;
  logic [ffpa_pkg::FUNC_W-1:0]   func_r, func_nxt;
  logic [ffpa_pkg::SIZE_W-1:0]   req_r, req_nxt;
  logic [ffpa_pkg::OFFS_W-1:0]   off_r, off_nxt;
  logic [MAX_BLOCKS-1:0]         onehot_r, onehot_nxt;
  logic [IDX_W-1:0]              idx_r, idx_nxt;
  logic                          found_r, found_nxt;
  logic [ffpa_pkg::STAT_W-1:0]   res_status_r, res_status_nxt;
  logic [ffpa_pkg::OFFS_W-1:0]   res_offset_r, res_offset_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [ffpa_pkg::STAT_W-1:0]   out_status_r, out_status_nxt;
  logic [ffpa_pkg::OFFS_W-1:0]   out_offset_r, out_offset_nxt;

  ffpa_pkg::cmd_op_t             cmd_op;
  logic [IDX_W-1:0]              cmd_idx;
  logic                          cmd_split;

  logic [MAX_BLOCKS-1:0]         valid_vec;
  logic [MAX_BLOCKS-1:0]         free_vec;
  logic [MAX_BLOCKS-1:0]         match_vec;
  logic [MAX_BLOCKS-1:0]         split_vec;
  logic [MAX_BLOCKS-1:0]         nxt_free_vec;
  logic [MAX_BLOCKS-1:0]         prv_free_vec;
  logic [ADDR_W-1:0]             start_a [MAX_BLOCKS];
  logic [ADDR_W-1:0]             size_a [MAX_BLOCKS];

  logic [MAX_BLOCKS-1:0]         pick;
  logic [IDX_W-1:0]              pick_idx;
  logic [ADDR_W-1:0]             sel_start;
  logic [SUM_W-1:0]              sel_sum;

  for (genvar k = 0; k < MAX_BLOCKS; k++) begin : g_cell
    localparam logic [IDX_W:0] K = (IDX_W + 1)'(k);
    ffpa_pkg::cell_ctl_t ctl;
    logic                lv, lf, rv, rf;
    logic [ADDR_W-1:0]   ls, lz, rs, rz;
    logic [IDX_W:0]      ci;

    assign ci = {1'b0, cmd_idx};

    always_comb begin
      ctl            = '0;
      ctl.eval       = cmd_op == ffpa_pkg::CMD_EVAL;
      ctl.set_used   = (cmd_op == ffpa_pkg::CMD_ALLOC) && (K == ci);
      ctl.trim       = (cmd_op == ffpa_pkg::CMD_ALLOC) && (K == ci) && cmd_split;
      ctl.split_in   = (cmd_op == ffpa_pkg::CMD_ALLOC) && cmd_split &&
                       (K == ci + 1'b1);
      ctl.take_left  = (cmd_op == ffpa_pkg::CMD_ALLOC) && cmd_split &&
                       (K > ci + 1'b1);
      ctl.set_free   = (cmd_op == ffpa_pkg::CMD_FREE) && (K == ci);
      ctl.absorb     = (cmd_op == ffpa_pkg::CMD_MERGE) && (K == ci);
      ctl.take_right = (cmd_op == ffpa_pkg::CMD_MERGE) && (K > ci);
    end

    if (k == 0) begin : g_left_edge
      assign lv = 1'b0;
      assign lf = 1'b0;
      assign ls = '0;
      assign lz = '0;
      assign prv_free_vec[k] = 1'b0;
    end else begin : g_left
      assign lv = valid_vec[k-1];
      assign lf = free_vec[k-1];
      assign ls = start_a[k-1];
      assign lz = size_a[k-1];
      assign prv_free_vec[k] = valid_vec[k-1] & free_vec[k-1];
    end

    if (k == MAX_BLOCKS - 1) begin : g_right_edge
      assign rv = 1'b0;
      assign rf = 1'b0;
      assign rs = '0;
      assign rz = '0;
      assign nxt_free_vec[k] = 1'b0;
    end else begin : g_right
      assign rv = valid_vec[k+1];
      assign rf = free_vec[k+1];
      assign rs = start_a[k+1];
      assign rz = size_a[k+1];
      assign nxt_free_vec[k] = valid_vec[k+1] & free_vec[k+1];
    end

    ffpa_cell #(
      .POOL_BYTES   (POOL_BYTES),
      .HEADER_BYTES (HEADER_BYTES),
      .IS_HEAD      (k == 0)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .func        (func_r),
      .req_size    (req_r),
      .free_offset (off_r),
      .left_valid  (lv),
      .left_free   (lf),
      .left_start  (ls),
      .left_size   (lz),
      .right_valid (rv),
      .right_free  (rf),
      .right_start (rs),
      .right_size  (rz),
      .valid       (valid_vec[k]),
      .free        (free_vec[k]),
      .start       (start_a[k]),
      .size        (size_a[k]),
      .match       (match_vec[k]),
      .split       (split_vec[k])
    );
  end

  assign pick = match_vec & (~match_vec + MAX_BLOCKS'(1));

  always_comb begin
    pick_idx = '0;
    for (int k = 0; k < MAX_BLOCKS; k++) begin
      if (pick[k]) begin
        pick_idx = pick_idx | IDX_W'(k);
      end
    end
  end

  always_comb begin
    sel_start = '0;
    for (int k = 0; k < MAX_BLOCKS; k++) begin
      if (onehot_r[k]) begin
        sel_start = sel_start | start_a[k];
      end
    end
  end

  assign sel_sum = SUM_W'(sel_start) + SUM_W'(HEADER_BYTES);

  always_comb begin
    state_nxt      = state_r;
    func_nxt       = func_r;
    req_nxt        = req_r;
    off_nxt        = off_r;
    onehot_nxt     = onehot_r;
    idx_nxt        = idx_r;
    found_nxt      = found_r;
    res_status_nxt = res_status_r;
    res_offset_nxt = res_offset_r;
    out_status_nxt = out_status_r;
    out_offset_nxt = out_offset_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    cmd_op         = ffpa_pkg::CMD_NONE;
    cmd_idx        = idx_r;
    cmd_split      = 1'b0;
    case (state_r)
      ffpa_pkg::S_IDLE: begin
        if (in_chan.valid) begin
          func_nxt = in_chan.func;
          req_nxt  = in_chan.req_size;
          off_nxt  = in_chan.free_offset;
          if (in_chan.func == ffpa_pkg::FUNC_ALLOC && in_chan.req_size == '0) begin
            res_status_nxt = ffpa_pkg::STATUS_ZERO;
            res_offset_nxt = '0;
            state_nxt      = ffpa_pkg::S_RESP;
          end else begin
            state_nxt = ffpa_pkg::S_EVAL;
          end
        end
      end
      ffpa_pkg::S_EVAL: begin
        cmd_op    = ffpa_pkg::CMD_EVAL;
        state_nxt = ffpa_pkg::S_DECIDE;
      end
      ffpa_pkg::S_DECIDE: begin
        onehot_nxt = pick;
        idx_nxt    = pick_idx;
        found_nxt  = |match_vec;
        state_nxt  = ffpa_pkg::S_ACT;
      end
      ffpa_pkg::S_ACT: begin
        state_nxt = ffpa_pkg::S_RESP;
        if (func_r == ffpa_pkg::FUNC_ALLOC) begin
          if (found_r) begin
            cmd_op         = ffpa_pkg::CMD_ALLOC;
            cmd_split      = (|(onehot_r & split_vec)) && !valid_vec[MAX_BLOCKS-1];
            res_status_nxt = ffpa_pkg::STATUS_OK;
            res_offset_nxt = sel_sum[ffpa_pkg::OFFS_W-1:0];
          end else begin
            res_status_nxt = ffpa_pkg::STATUS_NO_FIT;
            res_offset_nxt = '0;
          end
        end else begin
          res_offset_nxt = off_r;
          if (found_r && !(|(onehot_r & free_vec))) begin
            cmd_op         = ffpa_pkg::CMD_FREE;
            res_status_nxt = ffpa_pkg::STATUS_OK;
            state_nxt      = ffpa_pkg::S_MNEXT;
          end else begin
            res_status_nxt = ffpa_pkg::STATUS_BAD_FREE;
          end
        end
      end
      ffpa_pkg::S_MNEXT: begin
        if (|(onehot_r & nxt_free_vec)) begin
          cmd_op = ffpa_pkg::CMD_MERGE;
        end
        state_nxt = ffpa_pkg::S_MPREV;
      end
      ffpa_pkg::S_MPREV: begin
        if (|(onehot_r & prv_free_vec)) begin
          cmd_op  = ffpa_pkg::CMD_MERGE;
          cmd_idx = IDX_W'(idx_r - 1'b1);
        end
        state_nxt = ffpa_pkg::S_RESP;
      end
      ffpa_pkg::S_RESP: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_offset_nxt = res_offset_r;
          state_nxt      = ffpa_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = ffpa_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ffpa_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
      onehot_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      found_r     <= found_nxt;
      onehot_r    <= onehot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r       <= func_nxt;
    req_r        <= req_nxt;
    off_r        <= off_nxt;
    idx_r        <= idx_nxt;
    res_status_r <= res_status_nxt;
    res_offset_r <= res_offset_nxt;
    out_status_r <= out_status_nxt;
    out_offset_r <= out_offset_nxt;
  end

  assign in_chan.ready           = state_r == ffpa_pkg::S_IDLE;
  assign out_chan.valid          = out_valid_r;
  assign out_chan.status         = out_status_r;
  assign out_chan.payload_offset = out_offset_r;

  // The table always holds a run of valid entries starting at the first cell.
  a_table_packed: assert property (@(posedge clk) disable iff (!rst_n)
    valid_vec[0] && ((valid_vec & (valid_vec + MAX_BLOCKS'(1))) == '0))
    else $error("block table entries are not contiguous");

  // Coalescing leaves no two neighboring free blocks between requests.
  a_coalesced: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ffpa_pkg::S_IDLE) |-> ((free_vec & nxt_free_vec) == '0))
    else $error("adjacent free blocks left unmerged");

  // A found match selects exactly one cell.
  a_single_pick: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ffpa_pkg::S_ACT && found_r) |-> $onehot(onehot_r))
    else $error("first-fit selection is not one-hot");

endmodule
